// File: rtl/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants, types and helpers of the bilinear resize sampler.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int COORD_W    = 13;   // holds a source coordinate up to 8191
    localparam int DIM_W      = 14;   // holds an effective dimension up to 8192
    localparam int FRAC_W     = 17;   // Q17 fraction
    localparam int V_W        = 41;   // signed Q17 source coordinate
    localparam int WEIGHT_ONE = 2048;
    localparam int WEIGHT_W   = 12;
    localparam int SUM_SHIFT  = 22;
    localparam int HSUM_W     = 20;
    localparam int SUM_W      = 33;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_SCALE_X       = 2'd2,
        CFG_SCALE_Y       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [10:0] source_width;
        logic [10:0] source_height;
        logic [26:0] scale_x_q16;
        logic [26:0] scale_y_q16;
    } cfg_t;

    // One classified beat: a store write or a sample with its weights
    typedef struct packed {
        logic                query;
        logic                wr_ok;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [7:0]          pixel;
        logic [WEIGHT_W-1:0] wx0;
        logic [WEIGHT_W-1:0] wx1;
        logic [WEIGHT_W-1:0] wy0;
        logic [WEIGHT_W-1:0] wy1;
    } item_t;

    // round((1 - f) * WEIGHT_ONE), half up, f in Q17
    function automatic logic [WEIGHT_W-1:0] weight0(input logic [FRAC_W-1:0] frac);
        logic [33:0] p;
        p = (34'd131072 - 34'(frac)) * 34'(WEIGHT_ONE) + 34'd65536;
        return p[FRAC_W+WEIGHT_W-1:FRAC_W];
    endfunction

endpackage

// File: rtl/brs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_if
// Input and output channels of the bilinear resize sampler.
// ----------------------------------------------------------------------------
interface brs_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [9:0]  src_col;
    logic [9:0]  src_row;
    logic [7:0]  src_pixel;
    logic [11:0] dst_col;
    logic [11:0] dst_row;

    modport source (output valid, func, src_col, src_row, src_pixel, dst_col, dst_row,
                    input ready);
    modport sink (input valid, func, src_col, src_row, src_pixel, dst_col, dst_row,
                  output ready);
endinterface

interface brs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] dst_pixel;

    modport source (output valid, dst_pixel, input ready);
    modport sink (input valid, dst_pixel, output ready);
endinterface

// File: rtl/brs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/brs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_front
// Accepts beats, maps sample coordinates to the source grid, clamps them
// and derives the blend weights. Three stages, stalled as a whole.
// ----------------------------------------------------------------------------
module brs_front
    import brs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    brs_in_if.sink in_ch,
    input  cfg_t  cfg,
    input  logic  room,
    output logic  push,
    output item_t item
);

    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

    logic f1_v_reg, f1_v_next;
    logic f2_v_reg, f2_v_next;
    logic f3_v_reg, f3_v_next;

    logic        f1_func_reg;
    logic [9:0]  f1_col_reg;
    logic [9:0]  f1_row_reg;
    logic [7:0]  f1_pix_reg;
    logic [11:0] f1_dcol_reg;
    logic [11:0] f1_drow_reg;

    logic                    f2_func_reg;
    logic                    f2_wr_ok_reg;
    logic [9:0]              f2_col_reg;
    logic [9:0]              f2_row_reg;
    logic [7:0]              f2_pix_reg;
    logic signed [V_W-1:0]   f2_vx_reg;
    logic signed [V_W-1:0]   f2_vy_reg;
    logic [DIM_W-1:0]        f2_w_reg;
    logic [DIM_W-1:0]        f2_h_reg;

    item_t f3_item_reg;

    logic                  adv;
    logic [39:0]           prod_x;
    logic [39:0]           prod_y;
    logic signed [V_W-1:0] vx;
    logic signed [V_W-1:0] vy;
    logic [DIM_W-1:0]      sw;
    logic [DIM_W-1:0]      sh;
    logic [DIM_W-1:0]      w_eff;
    logic [DIM_W-1:0]      h_eff;
    logic                  wr_ok;

    logic signed [23:0]     sxf;
    logic signed [23:0]     syf;
    logic signed [24:0]     wm1;
    logic signed [24:0]     wm2;
    logic signed [24:0]     hm2;
    logic                   x_lo;
    logic                   x_hi;
    logic [COORD_W-1:0]     sx;
    logic [COORD_W-1:0]     sy;
    logic [FRAC_W-1:0]      fx;
    logic [FRAC_W-1:0]      fy;
    item_t                  item_next;

    assign adv         = room;
    assign in_ch.ready = adv;

    // Stage 2: Q17 source coordinate, effective dimensions, write range check
    always_comb
    begin
        prod_x = 40'({f1_dcol_reg, 1'b1}) * 40'(cfg.scale_x_q16);
        prod_y = 40'({f1_drow_reg, 1'b1}) * 40'(cfg.scale_y_q16);
        vx     = $signed({1'b0, prod_x}) - 41'sd65536;
        vy     = $signed({1'b0, prod_y}) - 41'sd65536;
        sw     = DIM_W'(cfg.source_width);
        sh     = DIM_W'(cfg.source_height);
        if (sw < DIM_W'(2))
            w_eff = DIM_W'(2);
        else if (sw > MAX_W)
            w_eff = MAX_W;
        else
            w_eff = sw;
        if (sh < DIM_W'(2))
            h_eff = DIM_W'(2);
        else if (sh > MAX_H)
            h_eff = MAX_H;
        else
            h_eff = sh;
        wr_ok = (DIM_W'(f1_col_reg) < MAX_W) && (DIM_W'(f1_row_reg) < MAX_H);
    end

    // Stage 3: floor, clamp, weights
    always_comb
    begin
        sxf  = $signed(f2_vx_reg[V_W-1:FRAC_W]);
        syf  = $signed(f2_vy_reg[V_W-1:FRAC_W]);
        wm1  = $signed({11'b0, f2_w_reg}) - 25'sd1;
        wm2  = $signed({11'b0, f2_w_reg}) - 25'sd2;
        hm2  = $signed({11'b0, f2_h_reg}) - 25'sd2;
        x_lo = sxf < 24'sd0;
        x_hi = 25'(sxf) >= wm1;
        fx   = f2_vx_reg[FRAC_W-1:0];
        fy   = f2_vy_reg[FRAC_W-1:0];
        if (x_lo)
        begin
            sx = '0;
            fx = '0;
        end
        else if (x_hi)
        begin
            sx = wm2[COORD_W-1:0];
            fx = '0;
        end
        else
        begin
            sx = sxf[COORD_W-1:0];
        end
        // a clamped row keeps its fraction
        if (25'(syf) > hm2)
            sy = hm2[COORD_W-1:0];
        else if (syf < 24'sd0)
            sy = '0;
        else
            sy = syf[COORD_W-1:0];

        item_next.query = (f2_func_reg == FUNC_SAMPLE);
        item_next.wr_ok = f2_wr_ok_reg;
        item_next.pixel = f2_pix_reg;
        item_next.wx0   = weight0(fx);
        item_next.wx1   = WEIGHT_W'(WEIGHT_ONE) - item_next.wx0;
        item_next.wy0   = weight0(fy);
        item_next.wy1   = WEIGHT_W'(WEIGHT_ONE) - item_next.wy0;
        if (f2_func_reg == FUNC_SAMPLE)
        begin
            item_next.col = sx;
            item_next.row = sy;
        end
        else
        begin
            item_next.col = COORD_W'(f2_col_reg);
            item_next.row = COORD_W'(f2_row_reg);
        end
    end

    always_comb
    begin
        f1_v_next = f1_v_reg;
        f2_v_next = f2_v_reg;
        f3_v_next = f3_v_reg;
        if (adv)
        begin
            f1_v_next = in_ch.valid;
            f2_v_next = f1_v_reg;
            f3_v_next = f2_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= f1_v_next;
            f2_v_reg <= f2_v_next;
            f3_v_reg <= f3_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_func_reg  <= in_ch.func;
            f1_col_reg   <= in_ch.src_col;
            f1_row_reg   <= in_ch.src_row;
            f1_pix_reg   <= in_ch.src_pixel;
            f1_dcol_reg  <= in_ch.dst_col;
            f1_drow_reg  <= in_ch.dst_row;
            f2_func_reg  <= f1_func_reg;
            f2_wr_ok_reg <= wr_ok;
            f2_col_reg   <= f1_col_reg;
            f2_row_reg   <= f1_row_reg;
            f2_pix_reg   <= f1_pix_reg;
            f2_vx_reg    <= vx;
            f2_vy_reg    <= vy;
            f2_w_reg     <= w_eff;
            f2_h_reg     <= h_eff;
            f3_item_reg  <= item_next;
        end
    end

    assign push = f3_v_reg && adv;
    assign item = f3_item_reg;

endmodule

// File: rtl/brs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_fifo
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module brs_fifo
    import brs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && push |-> pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

// File: rtl/brs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_back
// Drives the four-bank frame store and blends the 2x2 neighborhood.
// Banks are split by row and column parity so each neighbor has its own port.
// ----------------------------------------------------------------------------
module brs_back
    import brs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    input  item_t head,
    input  logic  empty,
    output logic  pop,
    brs_out_if.source out_ch
);

    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_D = HALF_W * HALF_H;
    localparam int AW     = $clog2(BANK_D);

    logic adv;

    logic [AW-1:0] bank_addr [4];
    logic          bank_we   [4];
    logic [7:0]    bank_data [4];

    logic                b1_v_reg, b1_v_next;
    logic                b1_q_reg;
    logic                b1_px_reg;
    logic                b1_py_reg;
    logic [WEIGHT_W-1:0] b1_wx0_reg, b1_wx1_reg, b1_wy0_reg, b1_wy1_reg;

    logic                b2_v_reg, b2_v_next;
    logic                b2_q_reg;
    logic [HSUM_W-1:0]   b2_h0_reg, b2_h1_reg;
    logic [WEIGHT_W-1:0] b2_wy0_reg, b2_wy1_reg;

    logic                out_v_reg, out_v_next;
    logic [7:0]          out_pix_reg;

    logic [7:0]          p00, p10, p01, p11;
    logic [HSUM_W-1:0]   h0, h1;
    logic [SUM_W-1:0]    sum;

    assign adv = !out_v_reg || out_ch.ready;
    assign pop = adv && !empty;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        localparam logic BC = 1'(k % 2);
        localparam logic BR = 1'(k / 2);
        logic [DIM_W-1:0] ci;
        logic [DIM_W-1:0] ri;

        // Column/row of this parity within the pair, halved
        assign ci = (DIM_W'(head.col) + DIM_W'(head.col[0] ^ BC)) >> 1;
        assign ri = (DIM_W'(head.row) + DIM_W'(head.row[0] ^ BR)) >> 1;
        assign bank_addr[k] = AW'(32'(ri) * 32'(HALF_W) + 32'(ci));
        assign bank_we[k]   = pop && !head.query && head.wr_ok
                              && (head.col[0] == BC) && (head.row[0] == BR);

        brs_ram #(
            .WIDTH(8),
            .DEPTH(BANK_D)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_we[k]),
            .wr_addr (bank_addr[k]),
            .wr_data (head.pixel),
            .rd_en   (adv),
            .rd_addr (bank_addr[k]),
            .rd_data (bank_data[k])
        );
    end

    // Route banks back to neighbor positions; bank index is {row parity, col parity}
    always_comb
    begin
        p00 = bank_data[{b1_py_reg, b1_px_reg}];
        p10 = bank_data[{b1_py_reg, ~b1_px_reg}];
        p01 = bank_data[{~b1_py_reg, b1_px_reg}];
        p11 = bank_data[{~b1_py_reg, ~b1_px_reg}];
        h0  = HSUM_W'(p00) * HSUM_W'(b1_wx0_reg) + HSUM_W'(p10) * HSUM_W'(b1_wx1_reg);
        h1  = HSUM_W'(p01) * HSUM_W'(b1_wx0_reg) + HSUM_W'(p11) * HSUM_W'(b1_wx1_reg);
        sum = SUM_W'(b2_h0_reg) * SUM_W'(b2_wy0_reg)
            + SUM_W'(b2_h1_reg) * SUM_W'(b2_wy1_reg);
    end

    always_comb
    begin
        b1_v_next  = b1_v_reg;
        b2_v_next  = b2_v_reg;
        out_v_next = out_v_reg;
        if (adv)
        begin
            b1_v_next  = pop;
            b2_v_next  = b1_v_reg;
            out_v_next = b2_v_reg && b2_q_reg;   // drop store writes here
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            b1_v_reg  <= b1_v_next;
            b2_v_reg  <= b2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_q_reg    <= head.query;
            b1_px_reg   <= head.col[0];
            b1_py_reg   <= head.row[0];
            b1_wx0_reg  <= head.wx0;
            b1_wx1_reg  <= head.wx1;
            b1_wy0_reg  <= head.wy0;
            b1_wy1_reg  <= head.wy1;
            b2_q_reg    <= b1_q_reg;
            b2_h0_reg   <= h0;
            b2_h1_reg   <= h1;
            b2_wy0_reg  <= b1_wy0_reg;
            b2_wy1_reg  <= b1_wy1_reg;
            out_pix_reg <= sum[SUM_SHIFT+7:SUM_SHIFT];
        end
    end

    assign out_ch.valid     = out_v_reg;
    assign out_ch.dst_pixel = out_pix_reg;

endmodule

// File: rtl/bilinear_resize_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_sampler_unit
// Bilinear resize sampler over a single-channel source frame store.
// A sample beat passes the front stages, the beat queue, the bank read and
// the blend stages before its result shows; store writes produce no result beat.
// Throughput: one beat per cycle while the output is not stalled, set by the
// four parity banks that deliver the whole 2x2 neighborhood in one read.
// Reset clears the control state and loads the default registers; the frame
// store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module bilinear_resize_sampler_unit
    import brs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    brs_in_if.sink      in_ch,
    brs_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [26:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    item_t push_item;
    item_t head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SOURCE_WIDTH:  cfg_next.source_width  = cfg_data[10:0];
                CFG_SOURCE_HEIGHT: cfg_next.source_height = cfg_data[10:0];
                CFG_SCALE_X:       cfg_next.scale_x_q16   = cfg_data;
                CFG_SCALE_Y:       cfg_next.scale_y_q16   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= 11'd1024;
            cfg_reg.source_height <= 11'd1024;
            cfg_reg.scale_x_q16   <= 27'd65536;
            cfg_reg.scale_y_q16   <= 27'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg_reg),
        .room  (!full || pop),
        .push  (push),
        .item  (push_item)
    );

    brs_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    brs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// File: tb/bilinear_resize_sampler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_sampler_unit_test
// Self-checking bench for the bilinear resize sampler. Store writes and
// sample beats are fed through a queue into a clocked driver. Every accepted
// sample is predicted in the bench, and a clocked monitor compares each
// output beat with the oldest prediction. Register settings change between
// phases, only while the block is idle. Before a sample is queued, writes
// are queued for any of its four neighbors not yet queued for a write.
// ----------------------------------------------------------------------------
module bilinear_resize_sampler_unit_test
    import brs_pkg::*;
();

    typedef struct {
        logic        func;
        logic [9:0]  src_col;
        logic [9:0]  src_row;
        logic [7:0]  src_pixel;
        logic [11:0] dst_col;
        logic [11:0] dst_row;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [26:0] cfg_data;

    brs_in_if  in_ch ();
    brs_out_if out_ch ();

    bilinear_resize_sampler_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    beat_t       beat_queue[$];
    logic [7:0]  pixel_queue[$];
    logic [7:0]  shadow_store[int];
    bit          planned_pixels[int];
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [26:0] scale_x_reg;
    logic [26:0] scale_y_reg;
    int          errors;
    bit          no_gaps;
    int          in_gap;
    int          out_gap;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        if (no_gaps || $urandom_range(0, 9) < 7)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_dim(logic [10:0] d);
        if (d < 2)
            return 2;
        if (d > 1024)
            return 1024;
        return d;
    endfunction

    // Floor and Q17 fraction of (dst + 0.5) * scale - 0.5, then clamp
    function automatic void map_coord(input logic [11:0] dst, input logic [26:0] scale,
                                      input int dim, input bit zero_frac,
                                      output int ipart, output longint frac);
        longint v;
        longint q;
        v = (longint'(dst) * 2 + 1) * longint'(scale) - 65536;
        q = v >>> 17;
        frac = v - q * 131072;
        ipart = int'(q);
        if (zero_frac)
        begin
            if (q < 0)
            begin
                ipart = 0;
                frac = 0;
            end
            if (q >= dim - 1)
            begin
                ipart = dim - 2;
                frac = 0;
            end
        end
        else
        begin
            if (q > dim - 2)
                ipart = dim - 2;
            if (q < 0)
                ipart = 0;
        end
    endfunction

    function automatic longint weight_near(longint frac);
        return ((131072 - frac) * WEIGHT_ONE + 65536) >>> 17;
    endfunction

    function automatic logic [7:0] blend_pixel(logic [11:0] dc, logic [11:0] dr);
        int     sx;
        int     sy;
        longint fx;
        longint fy;
        longint wx0;
        longint wy0;
        longint sum;
        map_coord(dr, scale_y_reg, clamp_dim(height_reg), 1'b0, sy, fy);
        map_coord(dc, scale_x_reg, clamp_dim(width_reg), 1'b1, sx, fx);
        wx0 = weight_near(fx);
        wy0 = weight_near(fy);
        sum = longint'(shadow_store[sy * 1024 + sx]) * wx0 * wy0
            + longint'(shadow_store[(sy + 1) * 1024 + sx]) * wx0 * (WEIGHT_ONE - wy0)
            + longint'(shadow_store[sy * 1024 + sx + 1]) * (WEIGHT_ONE - wx0) * wy0
            + longint'(shadow_store[(sy + 1) * 1024 + sx + 1])
              * (WEIGHT_ONE - wx0) * (WEIGHT_ONE - wy0);
        return 8'(sum >>> SUM_SHIFT);
    endfunction

    task automatic push_write(logic [9:0] col, logic [9:0] row);
        beat_t b;
        b.func      = FUNC_WRITE;
        b.src_col   = col;
        b.src_row   = row;
        b.src_pixel = 8'($urandom);
        b.dst_col   = 12'($urandom);
        b.dst_row   = 12'($urandom);
        planned_pixels[row * 1024 + col] = 1'b1;
        beat_queue = {beat_queue, b};
    endtask

    // Store any missing neighbor first so no unwritten entry is ever read
    task automatic push_sample(logic [11:0] dc, logic [11:0] dr);
        beat_t  b;
        int     sx;
        int     sy;
        longint f;
        map_coord(dr, scale_y_reg, clamp_dim(height_reg), 1'b0, sy, f);
        map_coord(dc, scale_x_reg, clamp_dim(width_reg), 1'b1, sx, f);
        for (int k = 0; k < 4; k++)
        begin
            if (!planned_pixels.exists((sy + k / 2) * 1024 + sx + k % 2))
                push_write(10'(sx + k % 2), 10'(sy + k / 2));
        end
        b.func      = FUNC_SAMPLE;
        b.src_col   = 10'($urandom);
        b.src_row   = 10'($urandom);
        b.src_pixel = 8'($urandom);
        b.dst_col   = dc;
        b.dst_row   = dr;
        beat_queue = {beat_queue, b};
    endtask

    task automatic wait_idle();
        while (beat_queue.size() != 0 || pixel_queue.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [26:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SOURCE_WIDTH:  width_reg   = value[10:0];
            CFG_SOURCE_HEIGHT: height_reg  = value[10:0];
            CFG_SCALE_X:       scale_x_reg = value;
            default:           scale_y_reg = value;
        endcase
    endtask

    task automatic load_setting(logic [10:0] w, logic [10:0] h, logic [26:0] sx,
                                logic [26:0] sy);
        write_reg(CFG_SOURCE_WIDTH, 27'(w));
        write_reg(CFG_SOURCE_HEIGHT, 27'(h));
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int count);
        logic [11:0] dc;
        logic [11:0] dr;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                push_write(10'($urandom), 10'($urandom));
            else
            begin
                dc = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
                dr = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
                push_sample(dc, dr);
            end
            // hold the sender once mid-phase until everything drains
            if (n == count / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    task automatic corner_samples();
        push_sample(12'd0, 12'd0);
        push_sample(12'd4095, 12'd4095);
        push_sample(12'd0, 12'd4095);
        push_sample(12'd4095, 12'd0);
        push_sample(12'd1, 12'd2);
    endtask

    initial
    begin
        errors      = 0;
        no_gaps     = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_SOURCE_WIDTH;
        cfg_data    = '0;
        width_reg   = 11'd1024;
        height_reg  = 11'd1024;
        scale_x_reg = 27'd65536;
        scale_y_reg = 27'd65536;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_WRITE;
        in_ch.src_col   = '0;
        in_ch.src_row   = '0;
        in_ch.src_pixel = '0;
        in_ch.dst_col   = '0;
        in_ch.dst_row   = '0;
        out_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset, with directed extremes
        push_write(10'd1023, 10'd1023);
        push_write(10'd0, 10'd0);
        beat_queue[$].src_pixel = 8'hFF;
        corner_samples();
        run_phase(50);

        no_gaps = 1'b1;
        load_setting(11'd0, 11'd1, 27'd0, 27'd0);
        corner_samples();
        run_phase(30);
        no_gaps = 1'b0;

        load_setting(11'd2047, 11'd2047, 27'h7FFFFFF, 27'd1);
        corner_samples();
        run_phase(45);

        load_setting(11'd2, 11'd2, 27'd67108864, 27'd16384);
        corner_samples();
        run_phase(35);

        load_setting(11'(1 + $urandom_range(1, 60)), 11'(1 + $urandom_range(1, 60)),
                     27'($urandom_range(1, 400000)), 27'($urandom_range(1, 400000)));
        corner_samples();
        run_phase(70);

        load_setting(11'd1024, 11'd1024, 27'd32768, 27'd98304);
        corner_samples();
        run_phase(70);

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Driver: hold a beat while stalled, predict on acceptance, then advance
    always @(posedge clk)
    begin
        beat_t b;
        if (rst_n && !(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid)
            begin
                b = beat_queue.pop_front();
                if (b.func == FUNC_WRITE)
                    shadow_store[b.src_row * 1024 + b.src_col] = b.src_pixel;
                else
                    pixel_queue = {pixel_queue, blend_pixel(b.dst_col, b.dst_row)};
                in_gap = pick_gap();
            end
            if (in_gap > 0 || beat_queue.size() == 0)
            begin
                if (in_gap > 0)
                    in_gap = in_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else
            begin
                b = beat_queue[0];
                in_ch.valid     <= 1'b1;
                in_ch.func      <= b.func;
                in_ch.src_col   <= b.src_col;
                in_ch.src_row   <= b.src_row;
                in_ch.src_pixel <= b.src_pixel;
                in_ch.dst_col   <= b.dst_col;
                in_ch.dst_row   <= b.dst_row;
            end
        end
    end

    // Monitor: check each output beat, then toggle ready with random gaps
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual %0d", $realtime, out_ch.dst_pixel);
                    errors = errors + 1;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (want !== out_ch.dst_pixel)
                    begin
                        $display("%0t: dst_pixel expected %0d actual %0d",
                                 $realtime, want, out_ch.dst_pixel);
                        errors = errors + 1;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_gap = pick_gap();
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        in_gap  = 0;
        out_gap = 0;
    end

endmodule

// File: filelist.f
rtl/brs_pkg.sv
rtl/brs_if.sv
rtl/brs_ram.sv
rtl/brs_front.sv
rtl/brs_fifo.sv
rtl/brs_back.sv
rtl/bilinear_resize_sampler_unit.sv
tb/bilinear_resize_sampler_unit_test.sv
